[rtl/quad_x_motor_mixer_unit_assert.svh]
// assertion helpers shared by the front and divider-step modules
`ifndef QUAD_X_MOTOR_MIXER_UNIT_ASSERT_SVH
`define QUAD_X_MOTOR_MIXER_UNIT_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define QXMM_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// condition must hold in the cycle after the trigger
`define QXMM_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

[rtl/qxmm_pkg.sv]
package qxmm_pkg;

   // fixed field widths
   localparam int LANES     = 4;
   localparam int DUTY_W    = 8;
   localparam int CORR_W    = 16;
   localparam int CSR_W     = 8;
   localparam int CSR_IDX_W = 1;

   // lane order of the result item
   localparam int LANE_FL = 0;
   localparam int LANE_FR = 1;
   localparam int LANE_RR = 2;
   localparam int LANE_RL = 3;

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DUTY_FLOOR   = 1'b0,
      CSR_DUTY_CEILING = 1'b1
   } csr_index_type;

   // quad-x sign table, a set bit subtracts that correction
   typedef struct packed {
      logic roll_neg;
      logic pitch_neg;
      logic yaw_neg;
   } mix_sign_type;

   localparam mix_sign_type [LANES-1:0] MIX_SIGN = {
      3'b011,  // rear left
      3'b110,  // rear right
      3'b101,  // front right
      3'b000   // front left
   };

   // per-item control that rides along the pipeline
   typedef struct packed {
      logic zero_thrust;
      logic scale;
   } item_flags_type;

   // scaled duty width (thrust, floor and ceiling with fraction bits)
   function automatic int thr_width(int frac_bits);
      return DUTY_W + frac_bits;
   endfunction

   // signed width of one motor sum
   function automatic int sum_width(int frac_bits);
      return ((thr_width(frac_bits) > CORR_W) ? thr_width(frac_bits) : CORR_W) + 3;
   endfunction

   // magnitude width of a positive sum
   function automatic int mag_width(int frac_bits);
      return sum_width(frac_bits) - 1;
   endfunction

   // width of sum times ceiling
   function automatic int prod_width(int frac_bits);
      return mag_width(frac_bits) + thr_width(frac_bits);
   endfunction

endpackage

[rtl/qxmm_front.sv]
`include "quad_x_motor_mixer_unit_assert.svh"

module qxmm_front
   import qxmm_pkg::*;
#(
   parameter int FRAC_BITS = 4
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   output logic                                          in_ready,
   input  logic [DUTY_W-1:0]                             thrust,
   input  logic signed [CORR_W-1:0]                      roll_correction,
   input  logic signed [CORR_W-1:0]                      pitch_correction,
   input  logic signed [CORR_W-1:0]                      yaw_correction,
   input  logic [DUTY_W-1:0]                             duty_ceiling,
   output logic                                          out_valid,
   input  logic                                          out_ready,
   output item_flags_type                                out_flags,
   output logic [LANES-1:0][sum_width(FRAC_BITS)-1:0]    out_mix,
   output logic [LANES-1:0][prod_width(FRAC_BITS)-1:0]   out_dividend,
   output logic [mag_width(FRAC_BITS)-1:0]               out_divisor
);

   localparam int TW  = thr_width(FRAC_BITS);
   localparam int SW  = sum_width(FRAC_BITS);
   localparam int MW  = mag_width(FRAC_BITS);
   localparam int PW  = prod_width(FRAC_BITS);
   localparam int NST = 5;

   logic [NST-1:0] vld_ff, vld_in, ld, up;

   logic [SW-1:0] t_ext, r_ext, p_ext, y_ext, hi_s;
   logic [TW-1:0] hi_t;

   logic [LANES-1:0][SW-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic [LANES-1:0][SW-1:0] m2_ff, m2_in, m3_ff, m4_ff;
   logic [SW-1:0]            pmax_a_ff, pmax_a_in, pmax_b_ff, pmax_b_in;
   logic [SW-1:0]            big4_ff, big4_in;
   logic                     scale4_in;
   logic [3:1]               tz_ff;
   item_flags_type           flags4_ff, flags5_ff;
   logic [LANES-1:0][SW-1:0] m5_ff;
   logic [LANES-1:0][PW-1:0] dvd5_ff, dvd5_in;
   logic [MW-1:0]            dvs5_ff;

   // stage handshake, a stage loads when it is empty or its successor loads
   always_comb begin
      up = {vld_ff[NST-2:0], in_valid};
      ld[NST-1] = !vld_ff[NST-1] || out_ready;
      for (int k = NST - 2; k >= 0; k--) begin
         ld[k] = !vld_ff[k] || ld[k+1];
      end
      vld_in = (ld & up) | (~ld & vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign in_ready = ld[0];

   // stage 1: thrust with roll, pitch with yaw
   always_comb begin
      t_ext = SW'(thrust) << FRAC_BITS;
      r_ext = SW'(roll_correction);
      p_ext = SW'(pitch_correction);
      y_ext = SW'(yaw_correction);
      for (int i = 0; i < LANES; i++) begin
         pa_in[i] = MIX_SIGN[i].roll_neg ? t_ext - r_ext : t_ext + r_ext;
         pb_in[i] = (MIX_SIGN[i].pitch_neg ? SW'(0) - p_ext : p_ext)
                    + (MIX_SIGN[i].yaw_neg ? SW'(0) - y_ext : y_ext);
      end
   end

   // stage 2: full motor sums
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         m2_in[i] = pa_ff[i] + pb_ff[i];
      end
   end

   // stage 3: pairwise maximum
   always_comb begin
      pmax_a_in = ($signed(m2_ff[1]) > $signed(m2_ff[0])) ? m2_ff[1] : m2_ff[0];
      pmax_b_in = ($signed(m2_ff[3]) > $signed(m2_ff[2])) ? m2_ff[3] : m2_ff[2];
   end

   // stage 4: largest sum and saturation check
   always_comb begin
      hi_t      = TW'(duty_ceiling) << FRAC_BITS;
      hi_s      = SW'(hi_t);
      big4_in   = ($signed(pmax_b_ff) > $signed(pmax_a_ff)) ? pmax_b_ff : pmax_a_ff;
      scale4_in = ($signed(pmax_a_ff) > $signed(hi_s)) || ($signed(pmax_b_ff) > $signed(hi_s));
   end

   // stage 5: sum times ceiling for positive lanes that need scaling
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (flags4_ff.scale && !m4_ff[i][SW-1] && (|m4_ff[i])) begin
            dvd5_in[i] = PW'(m4_ff[i][MW-1:0]) * PW'(hi_t);
         end else begin
            dvd5_in[i] = '0;
         end
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      if (ld[0] && up[0]) begin
         pa_ff    <= pa_in;
         pb_ff    <= pb_in;
         tz_ff[1] <= (thrust == '0);
      end
      if (ld[1] && up[1]) begin
         m2_ff    <= m2_in;
         tz_ff[2] <= tz_ff[1];
      end
      if (ld[2] && up[2]) begin
         m3_ff     <= m2_ff;
         pmax_a_ff <= pmax_a_in;
         pmax_b_ff <= pmax_b_in;
         tz_ff[3]  <= tz_ff[2];
      end
      if (ld[3] && up[3]) begin
         m4_ff                 <= m3_ff;
         big4_ff               <= big4_in;
         flags4_ff.zero_thrust <= tz_ff[3];
         flags4_ff.scale       <= scale4_in;
      end
      if (ld[4] && up[4]) begin
         m5_ff     <= m4_ff;
         dvd5_ff   <= dvd5_in;
         dvs5_ff   <= big4_ff[MW-1:0];
         flags5_ff <= flags4_ff;
      end
   end

   assign out_valid    = vld_ff[NST-1];
   assign out_flags    = flags5_ff;
   assign out_mix      = m5_ff;
   assign out_dividend = dvd5_ff;
   assign out_divisor  = dvs5_ff;

   // a scaled item always has a positive divisor
   `QXMM_ASSERT_NOW(a_front_divisor_positive, clock, reset,
      vld_ff[3] && flags4_ff.scale, !big4_ff[SW-1] && (big4_ff != '0),
      "scaled item reached the divider with a non-positive largest sum")

endmodule

[rtl/qxmm_div_step.sv]
`include "quad_x_motor_mixer_unit_assert.svh"

module qxmm_div_step
   import qxmm_pkg::*;
#(
   parameter int FRAC_BITS = 4,
   parameter int STEP      = 0
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   output logic                                          in_ready,
   input  item_flags_type                                in_flags,
   input  logic [LANES-1:0][sum_width(FRAC_BITS)-1:0]    in_mix,
   input  logic [LANES-1:0][prod_width(FRAC_BITS)-1:0]   in_rem,
   input  logic [LANES-1:0][thr_width(FRAC_BITS)-1:0]    in_quot,
   input  logic [mag_width(FRAC_BITS)-1:0]               in_divisor,
   output logic                                          out_valid,
   input  logic                                          out_ready,
   output item_flags_type                                out_flags,
   output logic [LANES-1:0][sum_width(FRAC_BITS)-1:0]    out_mix,
   output logic [LANES-1:0][prod_width(FRAC_BITS)-1:0]   out_rem,
   output logic [LANES-1:0][thr_width(FRAC_BITS)-1:0]    out_quot,
   output logic [mag_width(FRAC_BITS)-1:0]               out_divisor
);

   localparam int TW = thr_width(FRAC_BITS);
   localparam int SW = sum_width(FRAC_BITS);
   localparam int MW = mag_width(FRAC_BITS);
   localparam int PW = prod_width(FRAC_BITS);

   logic                     vld_ff, vld_in, ld;
   item_flags_type           flags_ff;
   logic [LANES-1:0][SW-1:0] mix_ff;
   logic [LANES-1:0][PW-1:0] rem_ff, rem_in;
   logic [LANES-1:0][TW-1:0] quot_ff, quot_in;
   logic [MW-1:0]            div_ff;
   logic [PW-1:0]            shifted, bound_shift;
   logic                     bound_ok;

   // handshake
   always_comb begin
      ld     = !vld_ff || out_ready;
      vld_in = ld ? in_valid : vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign in_ready = ld;

   // one restoring step: try the divisor at this quotient bit
   always_comb begin
      shifted = PW'(in_divisor) << STEP;
      for (int i = 0; i < LANES; i++) begin
         rem_in[i]  = in_rem[i];
         quot_in[i] = in_quot[i];
         if (in_rem[i] >= shifted) begin
            rem_in[i]        = in_rem[i] - shifted;
            quot_in[i][STEP] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld && in_valid) begin
         flags_ff <= in_flags;
         mix_ff   <= in_mix;
         rem_ff   <= rem_in;
         quot_ff  <= quot_in;
         div_ff   <= in_divisor;
      end
   end

   assign out_valid   = vld_ff;
   assign out_flags   = flags_ff;
   assign out_mix     = mix_ff;
   assign out_rem     = rem_ff;
   assign out_quot    = quot_ff;
   assign out_divisor = div_ff;

   // remainder after this step stays below the shifted divisor
   always_comb begin
      bound_shift = PW'(div_ff) << STEP;
      bound_ok    = 1'b1;
      for (int i = 0; i < LANES; i++) begin
         bound_ok = bound_ok && (rem_ff[i] < bound_shift);
      end
   end

   `QXMM_ASSERT_NOW(a_div_rem_bound, clock, reset,
      vld_ff && flags_ff.scale, bound_ok,
      "divider remainder not reduced below the shifted divisor")

   `QXMM_ASSERT_NEXT(a_div_stall_hold, clock, reset,
      vld_ff && !out_ready, vld_ff && $stable(rem_ff) && $stable(quot_ff),
      "stalled divider stage dropped or changed its item")

endmodule

[rtl/qxmm_back.sv]
module qxmm_back
   import qxmm_pkg::*;
#(
   parameter int FRAC_BITS = 4
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   output logic                                          in_ready,
   input  item_flags_type                                in_flags,
   input  logic [LANES-1:0][sum_width(FRAC_BITS)-1:0]    in_mix,
   input  logic [LANES-1:0][thr_width(FRAC_BITS)-1:0]    in_quot,
   input  logic [DUTY_W-1:0]                             duty_floor,
   input  logic [DUTY_W-1:0]                             duty_ceiling,
   output logic                                          out_valid,
   input  logic                                          out_ready,
   output logic [LANES-1:0][DUTY_W-1:0]                  out_duty
);

   localparam int SW = sum_width(FRAC_BITS);

   logic                         vld_ff, vld_in, ld;
   logic [LANES-1:0][DUTY_W-1:0] duty_ff, duty_in;
   logic [SW-1:0]                lo_s, hi_s, v, c;
   logic                         lo_gt_hi, lt_lo, gt_hi;

   // output register handshake
   always_comb begin
      ld     = !vld_ff || out_ready;
      vld_in = ld ? in_valid : vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign in_ready = ld;

   // pick scaled or raw sum, clamp to floor then ceiling, drop fraction bits, zero for zero thrust
   always_comb begin
      lo_s     = SW'(duty_floor) << FRAC_BITS;
      hi_s     = SW'(duty_ceiling) << FRAC_BITS;
      lo_gt_hi = (lo_s > hi_s);
      v        = '0;
      c        = '0;
      lt_lo    = 1'b0;
      gt_hi    = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         v     = in_flags.scale ? SW'(in_quot[i]) : in_mix[i];
         lt_lo = ($signed(v) < $signed(lo_s));
         gt_hi = ($signed(v) > $signed(hi_s));
         if (lt_lo) begin
            c = lo_gt_hi ? hi_s : lo_s;
         end else begin
            c = gt_hi ? hi_s : v;
         end
         duty_in[i] = in_flags.zero_thrust ? '0 : c[FRAC_BITS +: DUTY_W];
      end
   end

   always_ff @(posedge clock) begin
      if (ld && in_valid) begin
         duty_ff <= duty_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_duty  = duty_ff;

endmodule

[rtl/quad_x_motor_mixer_unit.sv]
// channel   | handshake            | payload
// ----------+----------------------+--------------------------------------------
// req       | req_valid/req_ready  | thrust, roll/pitch/yaw corrections
// rsp       | rsp_valid/rsp_ready  | front left/right, rear right/left duties
// csr       | csr_write_enable     | csr_index, csr_write_data (no read-back)
//
// one item enters per cycle while the output is not stalled; five mixing
// stages, one divider stage per quotient bit (8 + FRAC_BITS), one output stage.
// the quotient width of the pipelined restoring divider sets the depth.
// synchronous reset empties every stage and loads floor 0, ceiling 255.
// a stalled output register holds its item; empty stages upstream keep filling.
module quad_x_motor_mixer_unit
   import qxmm_pkg::*;
#(
   parameter int FRAC_BITS = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [DUTY_W-1:0]           req_thrust,
   input  logic signed [CORR_W-1:0]    req_roll_correction,
   input  logic signed [CORR_W-1:0]    req_pitch_correction,
   input  logic signed [CORR_W-1:0]    req_yaw_correction,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [DUTY_W-1:0]           rsp_front_left_duty,
   output logic [DUTY_W-1:0]           rsp_front_right_duty,
   output logic [DUTY_W-1:0]           rsp_rear_right_duty,
   output logic [DUTY_W-1:0]           rsp_rear_left_duty,
   input  logic                        csr_write_enable,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_W-1:0]            csr_write_data
);

   localparam int TW = thr_width(FRAC_BITS);
   localparam int SW = sum_width(FRAC_BITS);
   localparam int MW = mag_width(FRAC_BITS);
   localparam int PW = prod_width(FRAC_BITS);
   localparam int QW = TW;

   logic [DUTY_W-1:0] duty_floor_ff, duty_floor_in;
   logic [DUTY_W-1:0] duty_ceiling_ff, duty_ceiling_in;

   logic [QW:0]                       dv_vld, dv_rdy;
   item_flags_type [QW:0]             dv_flags;
   logic [QW:0][LANES-1:0][SW-1:0]    dv_mix;
   logic [QW:0][LANES-1:0][PW-1:0]    dv_rem;
   logic [QW:0][LANES-1:0][QW-1:0]    dv_quot;
   logic [QW:0][MW-1:0]               dv_div;

   logic [LANES-1:0][DUTY_W-1:0]      duty;

   // configuration registers
   always_comb begin
      duty_floor_in   = duty_floor_ff;
      duty_ceiling_in = duty_ceiling_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_DUTY_FLOOR: begin
               duty_floor_in = csr_write_data[DUTY_W-1:0];
            end
            CSR_DUTY_CEILING: begin
               duty_ceiling_in = csr_write_data[DUTY_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_floor_ff   <= '0;
         duty_ceiling_ff <= '1;
      end else begin
         duty_floor_ff   <= duty_floor_in;
         duty_ceiling_ff <= duty_ceiling_in;
      end
   end

   // sums, largest sum and dividend
   qxmm_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_valid),
      .in_ready         (req_ready),
      .thrust           (req_thrust),
      .roll_correction  (req_roll_correction),
      .pitch_correction (req_pitch_correction),
      .yaw_correction   (req_yaw_correction),
      .duty_ceiling     (duty_ceiling_ff),
      .out_valid        (dv_vld[0]),
      .out_ready        (dv_rdy[0]),
      .out_flags        (dv_flags[0]),
      .out_mix          (dv_mix[0]),
      .out_dividend     (dv_rem[0]),
      .out_divisor      (dv_div[0])
   );

   assign dv_quot[0] = '0;

   // pipelined divider, most significant quotient bit first
   for (genvar j = 0; j < QW; j++) begin : g_div
      qxmm_div_step #(
         .FRAC_BITS (FRAC_BITS),
         .STEP      (QW - 1 - j)
      ) u_step (
         .clock       (clock),
         .reset       (reset),
         .in_valid    (dv_vld[j]),
         .in_ready    (dv_rdy[j]),
         .in_flags    (dv_flags[j]),
         .in_mix      (dv_mix[j]),
         .in_rem      (dv_rem[j]),
         .in_quot     (dv_quot[j]),
         .in_divisor  (dv_div[j]),
         .out_valid   (dv_vld[j+1]),
         .out_ready   (dv_rdy[j+1]),
         .out_flags   (dv_flags[j+1]),
         .out_mix     (dv_mix[j+1]),
         .out_rem     (dv_rem[j+1]),
         .out_quot    (dv_quot[j+1]),
         .out_divisor (dv_div[j+1])
      );
   end

   // clamp and output register
   qxmm_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (dv_vld[QW]),
      .in_ready     (dv_rdy[QW]),
      .in_flags     (dv_flags[QW]),
      .in_mix       (dv_mix[QW]),
      .in_quot      (dv_quot[QW]),
      .duty_floor   (duty_floor_ff),
      .duty_ceiling (duty_ceiling_ff),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_duty     (duty)
   );

   assign rsp_front_left_duty  = duty[LANE_FL];
   assign rsp_front_right_duty = duty[LANE_FR];
   assign rsp_rear_right_duty  = duty[LANE_RR];
   assign rsp_rear_left_duty   = duty[LANE_RL];

endmodule

[tb/testbench.sv]
module testbench;
   import qxmm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC        = 4;
   localparam int PIPE_DEPTH  = 14 + FRAC;
   localparam int CYCLE_LIMIT = 400000;

   // one mixer command and one set of motor duties
   typedef struct packed {
      logic [DUTY_W-1:0] thrust;
      logic [CORR_W-1:0] roll;
      logic [CORR_W-1:0] pitch;
      logic [CORR_W-1:0] yaw;
   } mix_cmd_type;

   typedef struct packed {
      logic [DUTY_W-1:0] front_left;
      logic [DUTY_W-1:0] front_right;
      logic [DUTY_W-1:0] rear_right;
      logic [DUTY_W-1:0] rear_left;
   } duty_set_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [DUTY_W-1:0]        req_thrust;
   logic signed [CORR_W-1:0] req_roll_correction;
   logic signed [CORR_W-1:0] req_pitch_correction;
   logic signed [CORR_W-1:0] req_yaw_correction;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [DUTY_W-1:0]        rsp_front_left_duty;
   logic [DUTY_W-1:0]        rsp_front_right_duty;
   logic [DUTY_W-1:0]        rsp_rear_right_duty;
   logic [DUTY_W-1:0]        rsp_rear_left_duty;
   logic                     csr_write_enable;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_W-1:0]         csr_write_data;

   mix_cmd_type  pending_cmds[$];
   duty_set_type expected_duties[$];
   logic [DUTY_W-1:0] floor_duty;
   logic [DUTY_W-1:0] ceiling_duty;
   bit  quiet;
   int  cmds_sent;
   int  duties_checked;
   int  error_count;
   int  setting_count;
   int  cycle_count;
   int  send_gap;
   int  ready_hold;

   quad_x_motor_mixer_unit #(
      .FRAC_BITS(FRAC)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_thrust          (req_thrust),
      .req_roll_correction (req_roll_correction),
      .req_pitch_correction(req_pitch_correction),
      .req_yaw_correction  (req_yaw_correction),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_front_left_duty (rsp_front_left_duty),
      .rsp_front_right_duty(rsp_front_right_duty),
      .rsp_rear_right_duty (rsp_rear_right_duty),
      .rsp_rear_left_duty  (rsp_rear_left_duty),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   // clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // clamp to floor then ceiling, drop fraction bits
   function automatic logic [DUTY_W-1:0] clamp_duty(longint v, longint lo, longint hi);
      longint c;
      c = v;
      if (c < lo) c = lo;
      if (c > hi) c = hi;
      if (c < 0) c = 0;
      return DUTY_W'(c >>> FRAC);
   endfunction

   // quad-x mix with desaturation by ceiling over largest sum
   function automatic duty_set_type mix_duties(mix_cmd_type cmd);
      longint       t, r, p, y, lo, hi, big;
      longint       sums[4];
      duty_set_type d;
      t  = longint'(cmd.thrust) <<< FRAC;
      r  = longint'($signed(cmd.roll));
      p  = longint'($signed(cmd.pitch));
      y  = longint'($signed(cmd.yaw));
      lo = longint'(floor_duty) <<< FRAC;
      hi = longint'(ceiling_duty) <<< FRAC;
      if (cmd.thrust == 0) begin
         d = '0;
         return d;
      end
      sums[LANE_FL] = t + r + p + y;
      sums[LANE_FR] = t - r + p - y;
      sums[LANE_RR] = t - r - p + y;
      sums[LANE_RL] = t + r - p - y;
      big = sums[0];
      for (int i = 1; i < 4; i++) begin
         if (sums[i] > big) big = sums[i];
      end
      // scale all lanes down, division truncates toward zero
      if (big > hi) begin
         for (int i = 0; i < 4; i++) sums[i] = (sums[i] * hi) / big;
      end
      d.front_left  = clamp_duty(sums[LANE_FL], lo, hi);
      d.front_right = clamp_duty(sums[LANE_FR], lo, hi);
      d.rear_right  = clamp_duty(sums[LANE_RR], lo, hi);
      d.rear_left   = clamp_duty(sums[LANE_RL], lo, hi);
      return d;
   endfunction

   // idle length: mostly none or short, a few long
   function automatic int pick_gap();
      int dice;
      dice = $urandom_range(0, 99);
      if (quiet) return 0;
      if (dice < 55) return 0;
      if (dice < 88) return $urandom_range(1, 3);
      if (dice < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // correction: small, near the thrust scale, full range or extreme
   function automatic logic [CORR_W-1:0] rand_corr();
      int dice;
      int mag;
      dice = $urandom_range(0, 9);
      if (dice < 4) begin
         mag = $urandom_range(0, 512);
         return $urandom_range(0, 1) ? CORR_W'(-mag) : CORR_W'(mag);
      end
      if (dice < 7) begin
         mag = $urandom_range(0, 4096);
         return $urandom_range(0, 1) ? CORR_W'(-mag) : CORR_W'(mag);
      end
      if (dice < 9) return CORR_W'($urandom);
      case ($urandom_range(0, 3))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         default: return 16'hffff;
      endcase
   endfunction

   task automatic add_cmd(int thr, int r, int p, int y);
      mix_cmd_type cmd;
      cmd.thrust = DUTY_W'(thr);
      cmd.roll   = CORR_W'(r);
      cmd.pitch  = CORR_W'(p);
      cmd.yaw    = CORR_W'(y);
      pending_cmds.push_back(cmd);
   endtask

   task automatic add_random(int count);
      mix_cmd_type cmd;
      int          dice;
      for (int i = 0; i < count; i++) begin
         dice = $urandom_range(0, 19);
         if (dice == 0) cmd.thrust = '0;
         else if (dice == 1) cmd.thrust = '1;
         else if (dice == 2) cmd.thrust = 8'd1;
         else cmd.thrust = DUTY_W'($urandom);
         cmd.roll  = rand_corr();
         cmd.pitch = rand_corr();
         cmd.yaw   = rand_corr();
         pending_cmds.push_back(cmd);
      end
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      if (idx == CSR_DUTY_FLOOR) floor_duty = value;
      else ceiling_duty = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic configure(logic [CSR_W-1:0] fl, logic [CSR_W-1:0] ceil_v, bit no_idle);
      write_reg(CSR_DUTY_FLOOR, fl);
      write_reg(CSR_DUTY_CEILING, ceil_v);
      quiet = no_idle;
      setting_count++;
   endtask

   // wait until every command is sent and answered
   task automatic drain();
      while (pending_cmds.size() != 0 || cmds_sent != duties_checked) @(posedge clock);
   endtask

   // command driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid            <= 1'b0;
         req_thrust           <= '0;
         req_roll_correction  <= '0;
         req_pitch_correction <= '0;
         req_yaw_correction   <= '0;
         send_gap             <= 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_duties.push_back(mix_duties({req_thrust, req_roll_correction,
                                                  req_pitch_correction, req_yaw_correction}));
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               mix_cmd_type cmd;
               cmd = pending_cmds.pop_front();
               req_thrust           <= cmd.thrust;
               req_roll_correction  <= cmd.roll;
               req_pitch_correction <= cmd.pitch;
               req_yaw_correction   <= cmd.yaw;
               req_valid            <= 1'b1;
               send_gap             <= pick_gap();
               cmds_sent++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         ready_hold <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_duties.size() == 0) begin
               $error("result item with no command waiting");
               error_count++;
            end else begin
               duty_set_type want;
               want = expected_duties.pop_front();
               if (rsp_front_left_duty !== want.front_left) begin
                  $error("front_left_duty: expected %0d, got %0d",
                         want.front_left, rsp_front_left_duty);
                  error_count++;
               end
               if (rsp_front_right_duty !== want.front_right) begin
                  $error("front_right_duty: expected %0d, got %0d",
                         want.front_right, rsp_front_right_duty);
                  error_count++;
               end
               if (rsp_rear_right_duty !== want.rear_right) begin
                  $error("rear_right_duty: expected %0d, got %0d",
                         want.rear_right, rsp_rear_right_duty);
                  error_count++;
               end
               if (rsp_rear_left_duty !== want.rear_left) begin
                  $error("rear_left_duty: expected %0d, got %0d",
                         want.rear_left, rsp_rear_left_duty);
                  error_count++;
               end
               duties_checked++;
            end
         end
         if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready  <= 1'b1;
            ready_hold <= pick_gap();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // sequence of register settings and commands
   initial begin
      reset                <= 1'b1;
      csr_write_enable     <= 1'b0;
      csr_index            <= CSR_DUTY_FLOOR;
      csr_write_data       <= '0;
      floor_duty     = 8'd0;
      ceiling_duty   = 8'd255;
      quiet          = 1'b0;
      cmds_sent      = 0;
      duties_checked = 0;
      error_count    = 0;
      setting_count  = 1;
      cycle_count    = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed, reset settings
      add_cmd(0, 1000, -1000, 500);          // zero thrust
      add_cmd(0, 32767, 32767, 32767);
      add_cmd(255, 0, 0, 0);                 // exactly at ceiling
      add_cmd(1, 0, 0, 0);
      add_cmd(128, 0, 0, 0);
      add_cmd(255, 32767, 32767, 32767);     // heavy desaturation
      add_cmd(255, -32768, -32768, -32768);
      add_cmd(200, 1600, 0, 0);              // each axis alone pushes over
      add_cmd(200, 0, 1600, 0);
      add_cmd(200, 0, 0, 1600);
      add_cmd(200, -1600, 0, 0);
      add_cmd(10, -2000, 0, 0);              // negative sums
      add_cmd(1, -32768, 0, 0);
      add_cmd(255, -1, -1, -1);
      add_cmd(128, 32767, -32768, 0);
      add_cmd(64, 100, -200, 300);
      add_cmd(255, 16, 0, 0);                // just over the ceiling
      add_cmd(50, 0, -32768, 32767);
      drain();

      configure(8'd20, 8'd200, 1'b0);
      add_random(250);
      drain();

      // top extremes, no idling
      configure(8'd255, 8'd255, 1'b1);
      add_random(100);
      drain();

      configure(8'd0, 8'd1, 1'b0);
      add_random(100);
      drain();

      // floor above ceiling
      configure(8'd200, 8'd50, 1'b0);
      add_cmd(100, 0, 0, 0);
      add_cmd(5, -500, 0, 0);
      add_random(80);
      drain();

      // ceiling of zero
      configure(8'd10, 8'd0, 1'b0);
      add_cmd(100, 0, 0, 0);
      add_cmd(5, -500, 0, 0);
      add_cmd(5, -500, -500, -500);
      add_random(60);
      drain();

      for (int k = 0; k < 3; k++) begin
         configure(CSR_W'($urandom), CSR_W'($urandom_range(1, 255)), k == 1);
         add_random(100);
         drain();
      end

      // let any stray result show up
      repeat (2 * PIPE_DEPTH + 10) @(posedge clock);
      if (expected_duties.size() != 0) begin
         $error("%0d expected result items never arrived", expected_duties.size());
         error_count++;
      end

      $display("mixed %0d commands across %0d floor/ceiling settings, %0d duty sets checked",
               cmds_sent, setting_count, duties_checked);
      $display("covered zero thrust, desaturation, negative sums, floor over ceiling, zero ceiling");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
